// File: rtl/fnsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnsr_pkg
// Shared types and constants of the four nearest station rate interpolator.
// ----------------------------------------------------------------------------
package fnsr_pkg;

   localparam int CoordW = 24;
   localparam int CoefW  = 32;
   localparam int CloudW = 16;
   localparam int BandW  = 23;
   localparam int DiffW  = 25;
   localparam int SqW    = 50;
   localparam int DistW  = 25;
   localparam int RateW  = 32;
   localparam int ProdW  = 48;
   localparam int NumW   = 59;
   localparam int DenW   = 27;
   localparam int ModeW  = 2;
   localparam int StatW  = 2;
   localparam int NumCells = 4;

   localparam logic [BandW-1:0] BandReset = 23'd2560;

   localparam logic [ModeW-1:0] MODE_LOAD  = 2'd0;
   localparam logic [ModeW-1:0] MODE_QUERY = 2'd1;
   localparam logic [ModeW-1:0] MODE_CLEAR = 2'd2;

   localparam logic [StatW-1:0] ST_OK    = 2'd0;
   localparam logic [StatW-1:0] ST_SHORT = 2'd1;
   localparam logic [StatW-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                    valid;
      logic [DistW-1:0]        span;
      logic signed [RateW-1:0] rate;
   } cand_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_DIFF,
      S_SQ1,
      S_SQ2,
      S_SQST,
      S_SQRT,
      S_NEXT,
      S_DRAIN,
      S_MAC,
      S_DIVST,
      S_DIV,
      S_OUT
   } state_type;

endpackage

// File: rtl/fnsr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnsr_req_if
// Request channel: station load, query, clear or idle beat.
// ----------------------------------------------------------------------------
interface fnsr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [fnsr_pkg::ModeW-1:0]             mode;
   logic signed [fnsr_pkg::CoordW-1:0]     pos_x;
   logic signed [fnsr_pkg::CoordW-1:0]     pos_y;
   logic signed [fnsr_pkg::CoefW-1:0]      coef_slope;
   logic signed [fnsr_pkg::CoefW-1:0]      coef_offset;
   logic [fnsr_pkg::CloudW-1:0]            cloud_amount;

   modport source (output valid, mode, pos_x, pos_y, coef_slope, coef_offset,
                   cloud_amount, input ready);
   modport sink (input valid, mode, pos_x, pos_y, coef_slope, coef_offset,
                 cloud_amount, output ready);
endinterface

// File: rtl/fnsr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnsr_rsp_if
// Response channel: interpolated rate and status beat.
// ----------------------------------------------------------------------------
interface fnsr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fnsr_pkg::RateW-1:0]   rate_value;
   logic [fnsr_pkg::StatW-1:0]          status;

   modport source (output valid, rate_value, status, input ready);
   modport sink (input valid, rate_value, status, output ready);
endinterface

// File: rtl/fnsr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnsr_cell
// One slot of the sorted nearest list; passes displaced or farther entries downstream.
// ----------------------------------------------------------------------------
module fnsr_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  fnsr_pkg::cand_type cand_in,
   output fnsr_pkg::cand_type cand_out,
   output fnsr_pkg::cand_type held
);

   fnsr_pkg::cand_type held_ff, held_in;
   fnsr_pkg::cand_type out_ff, out_in;

   always_comb begin
      held_in = held_ff;
      out_in  = cand_in;
      out_in.valid = 1'b0;
      if (cand_in.valid) begin
         if (!held_ff.valid) begin
            held_in = cand_in;
         end else if (cand_in.span == held_ff.span) begin
            held_in.rate = cand_in.rate;
         end else if (cand_in.span < held_ff.span) begin
            held_in = cand_in;
            out_in  = held_ff;
         end else begin
            out_in = cand_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         held_ff.valid <= 1'b0;
         out_ff.valid  <= 1'b0;
      end else begin
         held_ff.valid <= held_in.valid;
         out_ff.valid  <= out_in.valid;
      end
      held_ff.span <= held_in.span;
      held_ff.rate <= held_in.rate;
      out_ff.span  <= out_in.span;
      out_ff.rate  <= out_in.rate;
   end

   assign cand_out = out_ff;
   assign held     = held_ff;

endmodule

// File: rtl/fnsr_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnsr_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fnsr_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [fnsr_pkg::SqW-1:0]       radicand,
   output logic                           done,
   output logic [fnsr_pkg::DistW-1:0]     root
);

   localparam int Steps = fnsr_pkg::SqW / 2;

   logic [fnsr_pkg::SqW-1:0] n_ff, n_in;
   logic [fnsr_pkg::SqW-1:0] root_ff, root_in;
   logic [fnsr_pkg::SqW-1:0] bit_ff, bit_in;
   logic [4:0]               cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [fnsr_pkg::SqW:0]   trial;

   always_comb begin
      trial   = {1'b0, root_ff} + {1'b0, bit_ff};
      n_in    = n_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = radicand;
         root_in = '0;
         bit_in  = {2'b01, {(fnsr_pkg::SqW-2){1'b0}}};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, n_ff} >= trial) begin
            n_in    = n_ff - trial[fnsr_pkg::SqW-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(Steps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff    <= n_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff[fnsr_pkg::DistW-1:0];

endmodule

// File: rtl/fnsr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnsr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fnsr_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fnsr_pkg::NumW-1:0]    dividend,
   input  logic [fnsr_pkg::DenW-1:0]    divisor,
   output logic                         done,
   output logic [fnsr_pkg::NumW-1:0]    quotient
);

   logic [fnsr_pkg::NumW-1:0] q_ff, q_in;
   logic [fnsr_pkg::DenW-1:0] rem_ff, rem_in;
   logic [fnsr_pkg::DenW-1:0] den_ff, den_in;
   logic [5:0]                cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [fnsr_pkg::DenW:0]   trial;

   always_comb begin
      trial   = {rem_ff, q_ff[fnsr_pkg::NumW-1]};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = fnsr_pkg::DenW'(trial - {1'b0, den_ff});
            q_in   = {q_ff[fnsr_pkg::NumW-2:0], 1'b1};
         end else begin
            rem_in = trial[fnsr_pkg::DenW-1:0];
            q_in   = {q_ff[fnsr_pkg::NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(fnsr_pkg::NumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: rtl/four_nearest_station_rate_interp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_nearest_station_rate_interp_core
// Station table with inverse-ordered distance weighting of the four nearest.
// ----------------------------------------------------------------------------
// Load, clear and idle beats pass from the accepting idle cycle straight to
// the output state. A query walks the stored stations: each station in the y
// band costs a memory read, a difference step, two squaring steps, a root
// start, an iterative square root and a push into the list; a station outside
// the band costs only the read, the difference step and the step to the next
// station. Then the four-cell nearest list drains, the weighted sum takes four
// multiply steps and an iterative divider finishes. A response that is not
// taken holds the block in its output state. One beat is in flight at a time;
// the response register lets the next request be taken while a result waits.
module four_nearest_station_rate_interp_core #(
   parameter int MAX_STATIONS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   fnsr_req_if.sink                      req_chan,
   fnsr_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [fnsr_pkg::BandW-1:0]    csr_wr_data
);

   localparam int IW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
   localparam int CW = $clog2(MAX_STATIONS + 1);
   localparam int EW = 2 * fnsr_pkg::CoordW + 2 * fnsr_pkg::CoefW;

   fnsr_pkg::state_type state_ff, state_nx;

   logic [EW-1:0] mem [MAX_STATIONS];
   logic [EW-1:0] rd_data_ff;

   logic [CW-1:0]                    count_ff;
   logic [IW-1:0]                    idx_ff;
   logic [fnsr_pkg::BandW-1:0]       band_ff;
   logic signed [fnsr_pkg::CoordW-1:0] qx_ff, qy_ff;
   logic [fnsr_pkg::CloudW-1:0]      cloud_ff;
   logic [fnsr_pkg::DiffW-1:0]       dx_ff, dy_ff, dx_in, dy_in;
   logic                             inband_ff, inband_in;
   logic signed [fnsr_pkg::ProdW-1:0] prod_ff;
   logic signed [fnsr_pkg::RateW-1:0] rate_ff, rate_in;
   logic [fnsr_pkg::SqW-1:0]         sq_ff;
   logic [fnsr_pkg::DistW-1:0]       dist_ff;
   logic [2:0]                       cnt_ff;
   logic signed [fnsr_pkg::NumW-1:0] acc_ff;
   logic [fnsr_pkg::DenW-1:0]        den_ff;
   logic signed [fnsr_pkg::RateW-1:0] res_rate_ff, rsp_rate_ff, res_rate_in;
   logic [fnsr_pkg::StatW-1:0]       res_stat_ff, rsp_stat_ff;
   logic                             rsp_valid_ff;

   logic signed [fnsr_pkg::CoordW-1:0] st_x, st_y;
   logic signed [fnsr_pkg::CoefW-1:0]  st_a, st_b;
   logic signed [fnsr_pkg::DiffW-1:0]  sx, sy;
   logic signed [40:0]                 rate_sum;
   logic signed [fnsr_pkg::ProdW:0]    ac_prod;
   logic signed [fnsr_pkg::NumW-2:0]   mac_term;
   logic [fnsr_pkg::SqW-1:0]           dx_sq, dy_sq;
   logic [fnsr_pkg::NumW-1:0]          mag, q;
   logic [fnsr_pkg::NumW-1:0]          dividend;
   logic                               all_valid;
   fnsr_pkg::cand_type                 sel;
   fnsr_pkg::cand_type                 sel_rev;

   logic accept, push, clear_list, sqrt_start, div_start, out_fire, last_idx;
   logic sqrt_done, div_done;
   logic [fnsr_pkg::DistW-1:0] sqrt_root;

   fnsr_pkg::cand_type chain [fnsr_pkg::NumCells+1];
   fnsr_pkg::cand_type held  [fnsr_pkg::NumCells];

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_fire = (state_ff == fnsr_pkg::S_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   assign last_idx = (CW'(idx_ff) + CW'(1)) == count_ff;

   assign {st_x, st_y, st_a, st_b} = rd_data_ff;

   // cells
   assign chain[0] = '{valid: push, span: dist_ff, rate: rate_ff};

   for (genvar g = 0; g < fnsr_pkg::NumCells; g++) begin : g_cell
      fnsr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (clear_list),
         .cand_in  (chain[g]),
         .cand_out (chain[g+1]),
         .held     (held[g])
      );
   end

   fnsr_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   fnsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (q)
   );

   // next state
   always_comb begin
      state_nx = state_ff;
      case (state_ff)
         fnsr_pkg::S_IDLE: begin
            if (accept) begin
               if (req_chan.mode == fnsr_pkg::MODE_QUERY) begin
                  state_nx = (count_ff == '0) ? fnsr_pkg::S_DRAIN : fnsr_pkg::S_READ;
               end else begin
                  state_nx = fnsr_pkg::S_OUT;
               end
            end
         end
         fnsr_pkg::S_READ:  state_nx = fnsr_pkg::S_DIFF;
         fnsr_pkg::S_DIFF:  state_nx = inband_in ? fnsr_pkg::S_SQ1 : fnsr_pkg::S_NEXT;
         fnsr_pkg::S_SQ1:   state_nx = fnsr_pkg::S_SQ2;
         fnsr_pkg::S_SQ2:   state_nx = fnsr_pkg::S_SQST;
         fnsr_pkg::S_SQST:  state_nx = fnsr_pkg::S_SQRT;
         fnsr_pkg::S_SQRT: begin
            if (sqrt_done) state_nx = fnsr_pkg::S_NEXT;
         end
         fnsr_pkg::S_NEXT:  state_nx = last_idx ? fnsr_pkg::S_DRAIN : fnsr_pkg::S_READ;
         fnsr_pkg::S_DRAIN: begin
            if (cnt_ff == 3'd3) state_nx = fnsr_pkg::S_MAC;
         end
         fnsr_pkg::S_MAC: begin
            if (cnt_ff == 3'd3) state_nx = fnsr_pkg::S_DIVST;
         end
         fnsr_pkg::S_DIVST: begin
            state_nx = (all_valid && den_ff != '0) ? fnsr_pkg::S_DIV : fnsr_pkg::S_OUT;
         end
         fnsr_pkg::S_DIV: begin
            if (div_done) state_nx = fnsr_pkg::S_OUT;
         end
         fnsr_pkg::S_OUT: begin
            if (out_fire) state_nx = fnsr_pkg::S_IDLE;
         end
         default: state_nx = fnsr_pkg::S_IDLE;
      endcase
   end

   // controls
   always_comb begin
      req_chan.ready = 1'b0;
      push       = 1'b0;
      clear_list = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         fnsr_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            clear_list     = accept && (req_chan.mode == fnsr_pkg::MODE_QUERY);
         end
         fnsr_pkg::S_SQST:  sqrt_start = 1'b1;
         fnsr_pkg::S_NEXT:  push = inband_ff;
         fnsr_pkg::S_DIVST: div_start = all_valid && (den_ff != '0);
         default: ;
      endcase
   end

   // datapath helpers
   always_comb begin
      sx = fnsr_pkg::DiffW'(st_x) - fnsr_pkg::DiffW'(qx_ff);
      sy = fnsr_pkg::DiffW'(st_y) - fnsr_pkg::DiffW'(qy_ff);
      dx_in = sx[fnsr_pkg::DiffW-1] ? fnsr_pkg::DiffW'(-sx) : fnsr_pkg::DiffW'(sx);
      dy_in = sy[fnsr_pkg::DiffW-1] ? fnsr_pkg::DiffW'(-sy) : fnsr_pkg::DiffW'(sy);
      inband_in = dy_in <= {2'b00, band_ff};

      ac_prod = st_a * $signed({1'b0, cloud_ff});
      dx_sq   = dx_ff * dx_ff;
      dy_sq   = dy_ff * dy_ff;

      rate_sum = 41'(prod_ff >>> 8) + 41'(st_b);
      if (rate_sum > 41'sd2147483647) begin
         rate_in = 32'sh7FFFFFFF;
      end else if (rate_sum < -41'sd2147483648) begin
         rate_in = 32'sh80000000;
      end else begin
         rate_in = rate_sum[fnsr_pkg::RateW-1:0];
      end

      all_valid = held[0].valid && held[1].valid && held[2].valid && held[3].valid;
      sel     = held[cnt_ff[1:0]];
      sel_rev = held[2'd3 - cnt_ff[1:0]];
      mac_term = sel_rev.rate * $signed({1'b0, sel.span});

      mag = acc_ff[fnsr_pkg::NumW-1] ? fnsr_pkg::NumW'(-acc_ff) : fnsr_pkg::NumW'(acc_ff);
      dividend = mag + fnsr_pkg::NumW'(den_ff >> 1);

      if (!acc_ff[fnsr_pkg::NumW-1]) begin
         res_rate_in = (q > 59'd2147483647) ? 32'sh7FFFFFFF : q[31:0];
      end else begin
         res_rate_in = (q > 59'd2147483648) ? 32'sh80000000 : 32'(-q[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[idx_ff];
      if (accept && req_chan.mode == fnsr_pkg::MODE_LOAD && count_ff < CW'(MAX_STATIONS)) begin
         mem[count_ff[IW-1:0]] <= {req_chan.pos_x, req_chan.pos_y,
                                   req_chan.coef_slope, req_chan.coef_offset};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fnsr_pkg::S_IDLE;
         count_ff     <= '0;
         band_ff      <= fnsr_pkg::BandReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_nx;
         if (csr_wr_en) band_ff <= csr_wr_data;
         if (accept) begin
            if (req_chan.mode == fnsr_pkg::MODE_LOAD && count_ff < CW'(MAX_STATIONS)) begin
               count_ff <= count_ff + CW'(1);
            end else if (req_chan.mode == fnsr_pkg::MODE_CLEAR) begin
               count_ff <= '0;
            end
         end
         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (accept) begin
         qx_ff       <= req_chan.pos_x;
         qy_ff       <= req_chan.pos_y;
         cloud_ff    <= req_chan.cloud_amount;
         idx_ff      <= '0;
         cnt_ff      <= '0;
         acc_ff      <= '0;
         den_ff      <= '0;
         res_rate_ff <= '0;
         res_stat_ff <= (req_chan.mode == fnsr_pkg::MODE_LOAD &&
                         count_ff >= CW'(MAX_STATIONS)) ? fnsr_pkg::ST_FULL
                                                        : fnsr_pkg::ST_OK;
      end

      case (state_ff)
         fnsr_pkg::S_DIFF: begin
            dx_ff     <= dx_in;
            dy_ff     <= dy_in;
            inband_ff <= inband_in;
            prod_ff   <= ac_prod[fnsr_pkg::ProdW-1:0];
         end
         fnsr_pkg::S_SQ1: begin
            sq_ff   <= dx_sq;
            rate_ff <= rate_in;
         end
         fnsr_pkg::S_SQ2: sq_ff <= sq_ff + dy_sq;
         fnsr_pkg::S_SQRT: begin
            if (sqrt_done) dist_ff <= sqrt_root;
         end
         fnsr_pkg::S_NEXT: begin
            if (!last_idx) idx_ff <= idx_ff + IW'(1);
         end
         fnsr_pkg::S_DRAIN: cnt_ff <= (cnt_ff == 3'd3) ? 3'd0 : cnt_ff + 3'd1;
         fnsr_pkg::S_MAC: begin
            acc_ff <= acc_ff + fnsr_pkg::NumW'(mac_term);
            den_ff <= den_ff + fnsr_pkg::DenW'(sel.span);
            cnt_ff <= cnt_ff + 3'd1;
         end
         fnsr_pkg::S_DIVST: begin
            if (!(all_valid && den_ff != '0)) begin
               res_stat_ff <= fnsr_pkg::ST_SHORT;
               res_rate_ff <= '0;
            end
         end
         fnsr_pkg::S_DIV: begin
            if (div_done) begin
               res_rate_ff <= res_rate_in;
               res_stat_ff <= fnsr_pkg::ST_OK;
            end
         end
         default: ;
      endcase

      if (out_fire) begin
         rsp_rate_ff <= res_rate_ff;
         rsp_stat_ff <= res_stat_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.rate_value = rsp_rate_ff;
   assign rsp_chan.status     = rsp_stat_ff;

endmodule

// File: bench/four_nearest_station_rate_interp_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_nearest_station_rate_interp_core_test
// Self-checking bench for the station table and four-nearest rate interpolator.
// Loads, queries, clears and idle beats are predicted in the bench and each
// response beat is compared with the oldest prediction. Both channels idle at
// random, with long receiver hold-offs and full drains between band settings.
// ----------------------------------------------------------------------------
module four_nearest_station_rate_interp_core_test;

   localparam logic [fnsr_pkg::ModeW-1:0] MODE_NOP = 2'd3;
   localparam int TableDepth = 256;
   localparam int CycleLimit = 10000000;
   localparam int CoordMin = -8388608;
   localparam int CoordMax = 8388607;

   typedef struct packed {
      logic signed [fnsr_pkg::RateW-1:0] rate;
      logic [fnsr_pkg::StatW-1:0]        status;
   } rate_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [fnsr_pkg::BandW-1:0] csr_wr_data = '0;

   fnsr_req_if req ();
   fnsr_rsp_if rsp ();

   four_nearest_station_rate_interp_core #(.MAX_STATIONS(TableDepth)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req),
      .rsp_chan   (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bench copy of the station table
   int            tab_x [TableDepth];
   int            tab_y [TableDepth];
   int            tab_a [TableDepth];
   int            tab_b [TableDepth];
   int unsigned   tab_count;
   int unsigned   band_width;

   rate_beat_type pending_rates[$];
   int            mismatches;
   int            beats_checked;
   int            ok_queries;
   int            cycle_count;
   int            hold_request;
   bit            steady_ready;

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned abs_gap(longint p, longint q);
      return (p >= q) ? longint'(p - q) : longint'(q - p);
   endfunction

   function automatic rate_beat_type interp_query(int qx, int qy, int cloud);
      rate_beat_type res;
      longint unsigned near_d[4];
      longint near_r[4];
      longint unsigned d, den, mag, quo;
      longint r, num;
      int used, last;
      bit placed;
      res.rate = '0;
      res.status = fnsr_pkg::ST_OK;
      used = 0;
      for (int i = 0; i < tab_count; i++) begin
         if (abs_gap(tab_y[i], qy) > band_width) continue;
         d = abs_gap(tab_x[i], qx) * abs_gap(tab_x[i], qx)
             + abs_gap(tab_y[i], qy) * abs_gap(tab_y[i], qy);
         d = floor_root(d);
         r = clamp32(((longint'(tab_a[i]) * longint'(cloud)) >>> 8) + tab_b[i]);
         placed = 0;
         for (int k = 0; k < used; k++) begin
            if (near_d[k] == d) begin
               near_r[k] = r;
               placed = 1;
               break;
            end
            if (d < near_d[k]) begin
               last = (used < 4) ? used : 3;
               for (int j = last; j > k; j--) begin
                  near_d[j] = near_d[j-1];
                  near_r[j] = near_r[j-1];
               end
               near_d[k] = d;
               near_r[k] = r;
               if (used < 4) used++;
               placed = 1;
               break;
            end
         end
         if (!placed && used < 4) begin
            near_d[used] = d;
            near_r[used] = r;
            used++;
         end
      end
      if (used < 4) begin
         res.status = fnsr_pkg::ST_SHORT;
         return res;
      end
      den = near_d[0] + near_d[1] + near_d[2] + near_d[3];
      if (den == 0) begin
         res.status = fnsr_pkg::ST_SHORT;
         return res;
      end
      num = near_r[3] * longint'(near_d[0]) + near_r[2] * longint'(near_d[1])
            + near_r[1] * longint'(near_d[2]) + near_r[0] * longint'(near_d[3]);
      mag = (num < 0) ? longint'(-num) : num;
      quo = (mag + den / 2) / den;
      res.rate = 32'(clamp32((num < 0) ? -longint'(quo) : longint'(quo)));
      return res;
   endfunction

   function automatic rate_beat_type apply_beat(logic [fnsr_pkg::ModeW-1:0] mode, int px,
                                                int py, int ca, int cb, int cloud);
      rate_beat_type res;
      res.rate = '0;
      res.status = fnsr_pkg::ST_OK;
      case (mode)
         fnsr_pkg::MODE_LOAD: begin
            if (tab_count < TableDepth) begin
               tab_x[tab_count] = px;
               tab_y[tab_count] = py;
               tab_a[tab_count] = ca;
               tab_b[tab_count] = cb;
               tab_count++;
            end else begin
               res.status = fnsr_pkg::ST_FULL;
            end
         end
         fnsr_pkg::MODE_QUERY: res = interp_query(px, py, cloud);
         fnsr_pkg::MODE_CLEAR: tab_count = 0;
         default: ;
      endcase
      return res;
   endfunction

   task automatic send_beat(logic [fnsr_pkg::ModeW-1:0] mode, int px, int py, int ca,
                            int cb, int cloud);
      int gap, pick;
      pick = $urandom_range(0, 99);
      gap = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.mode         <= mode;
      req.pos_x        <= px[fnsr_pkg::CoordW-1:0];
      req.pos_y        <= py[fnsr_pkg::CoordW-1:0];
      req.coef_slope   <= ca;
      req.coef_offset  <= cb;
      req.cloud_amount <= cloud[fnsr_pkg::CloudW-1:0];
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending_rates.push_back(apply_beat(mode, px, py, ca, cb, cloud));
   endtask

   task automatic drain_results();
      @(posedge clock);
      req.valid <= 1'b0;
      while (pending_rates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_band(int unsigned value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[fnsr_pkg::BandW-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      band_width = value;
      @(posedge clock);
   endtask

   function automatic int near_coord(int center, int spread);
      longint v;
      v = longint'(center) + $urandom_range(0, 2 * spread) - spread;
      if (v > CoordMax) v = CoordMax;
      if (v < CoordMin) v = CoordMin;
      return int'(v);
   endfunction

   function automatic int any_coord();
      return near_coord(0, CoordMax);
   endfunction

   // --- tests ---------------------------------------------------------------

   task automatic test_extremes();
      send_beat(fnsr_pkg::MODE_QUERY, 0, 0, 0, 0, 0);
      send_beat(fnsr_pkg::MODE_LOAD, CoordMax, CoordMax, 32'sh7fffffff, 32'sh7fffffff, 0);
      send_beat(fnsr_pkg::MODE_LOAD, CoordMin, CoordMax, 32'sh80000000, 32'sh80000000, 0);
      send_beat(fnsr_pkg::MODE_LOAD, 0, CoordMax - 100, 32'sh00010000, 0, 0);
      send_beat(fnsr_pkg::MODE_LOAD, 5000, CoordMax - 2000, -32'sh00020000, 32'sh00001234,
                0);
      send_beat(fnsr_pkg::MODE_QUERY, 0, CoordMax, 0, 0, 16'hffff);
      send_beat(fnsr_pkg::MODE_QUERY, 0, CoordMax, 0, 0, 0);
      send_beat(MODE_NOP, CoordMax, CoordMin, -1, -1, 16'hffff);
      send_beat(fnsr_pkg::MODE_QUERY, CoordMin, CoordMin, 0, 0, 100);
      send_beat(fnsr_pkg::MODE_CLEAR, 0, 0, 0, 0, 0);
      send_beat(fnsr_pkg::MODE_QUERY, 0, CoordMax, 0, 0, 256);
   endtask

   task automatic test_equal_distances();
      send_beat(fnsr_pkg::MODE_LOAD, 1000, 0, 32'sh00010000, 32'sh00050000, 0);
      send_beat(fnsr_pkg::MODE_LOAD, -1000, 0, 32'sh00020000, -32'sh00010000, 0);
      send_beat(fnsr_pkg::MODE_LOAD, 2000, 0, 32'sh00030000, 0, 0);
      send_beat(fnsr_pkg::MODE_LOAD, 0, 1500, -32'sh00010000, 32'sh00008000, 0);
      send_beat(fnsr_pkg::MODE_QUERY, 0, 0, 0, 0, 300);
      send_beat(fnsr_pkg::MODE_LOAD, 0, -2500, 32'sh00007000, 32'sh00001000, 0);
      send_beat(fnsr_pkg::MODE_QUERY, 0, 0, 0, 0, 300);
      send_beat(fnsr_pkg::MODE_CLEAR, 0, 0, 0, 0, 0);
   endtask

   task automatic test_band_settings();
      int picks[5];
      picks = '{0, 8388607, 600, 100000, 2560};
      foreach (picks[p]) begin
         write_band(picks[p]);
         send_beat(fnsr_pkg::MODE_CLEAR, 0, 0, 0, 0, 0);
         for (int i = 0; i < 12; i++)
            send_beat(fnsr_pkg::MODE_LOAD, near_coord(0, 8000), near_coord(0, 3000),
                      $urandom, $urandom, 0);
         repeat (3) send_beat(fnsr_pkg::MODE_QUERY, near_coord(0, 4000),
                              near_coord(0, 2000), 0, 0, $urandom_range(0, 65535));
      end
      send_beat(fnsr_pkg::MODE_CLEAR, 0, 0, 0, 0, 0);
   endtask

   task automatic test_full_table();
      write_band(8388607);
      for (int i = 0; i <= TableDepth; i++)
         send_beat(fnsr_pkg::MODE_LOAD, any_coord(), any_coord(), $urandom, $urandom, 0);
      send_beat(fnsr_pkg::MODE_QUERY, any_coord(), any_coord(), 0, 0,
                $urandom_range(0, 65535));
      send_beat(fnsr_pkg::MODE_LOAD, 0, 0, 0, 0, 0);
      send_beat(fnsr_pkg::MODE_CLEAR, 0, 0, 0, 0, 0);
      write_band(2560);
   endtask

   task automatic test_backpressure();
      hold_request = 400;
      for (int i = 0; i < 30; i++)
         send_beat((i % 3 == 0) ? MODE_NOP : fnsr_pkg::MODE_LOAD, near_coord(0, 3000),
                   near_coord(0, 1500), $urandom, $urandom, 0);
      send_beat(fnsr_pkg::MODE_QUERY, 0, 0, 0, 0, $urandom_range(0, 65535));
      drain_results();
      send_beat(fnsr_pkg::MODE_CLEAR, 0, 0, 0, 0, 0);
   endtask

   task automatic test_random(int total);
      int cx, cy, pick;
      int unsigned bands[4];
      bands = '{2560, 1200, 6000, 8388607};
      cx = any_coord();
      cy = any_coord();
      for (int n = 0; n < total; n++) begin
         if (n % 300 == 299) write_band(bands[(n / 300) % 4]);
         if (n % 60 == 0) begin
            cx = any_coord();
            cy = any_coord();
         end
         pick = $urandom_range(0, 99);
         if (tab_count >= 24 || pick < 3) begin
            send_beat(fnsr_pkg::MODE_CLEAR, any_coord(), any_coord(), $urandom, $urandom,
                      $urandom);
         end else if (pick < 45) begin
            send_beat(fnsr_pkg::MODE_LOAD, near_coord(cx, 4000), near_coord(cy, 2500),
                      $urandom, $urandom, $urandom);
         end else if (pick < 90) begin
            send_beat(fnsr_pkg::MODE_QUERY, near_coord(cx, 2500), near_coord(cy, 1500),
                      $urandom, $urandom, $urandom_range(0, 65535));
         end else if (pick < 94) begin
            send_beat(MODE_NOP, any_coord(), any_coord(), $urandom, $urandom, $urandom);
         end else begin
            send_beat((pick < 97) ? fnsr_pkg::MODE_LOAD : fnsr_pkg::MODE_QUERY, any_coord(),
                      any_coord(), $urandom, $urandom, $urandom_range(0, 65535));
         end
      end
   endtask

   // --- receiver -------------------------------------------------------------

   int stall_left = 0;

   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp.ready <= 1'b0;
      end else if (steady_ready) begin
         rsp.ready <= 1'b1;
      end else begin
         if ($urandom_range(0, 999) < 5) stall_left = $urandom_range(20, 120);
         rsp.ready <= ($urandom_range(0, 99) < 75);
      end
   end

   always @(posedge clock) begin
      rate_beat_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         beats_checked++;
         if (pending_rates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: rate %0d status %0d", rsp.rate_value, rsp.status);
         end else begin
            want = pending_rates.pop_front();
            if (want.status == fnsr_pkg::ST_OK && want.rate != 0) ok_queries++;
            if (rsp.rate_value !== want.rate || rsp.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d mismatch: rate exp %0d got %0d, status exp %0d got %0d",
                           beats_checked, want.rate, rsp.rate_value, want.status,
                           rsp.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req.valid        <= 1'b0;
      req.mode         <= MODE_NOP;
      req.pos_x        <= '0;
      req.pos_y        <= '0;
      req.coef_slope   <= '0;
      req.coef_offset  <= '0;
      req.cloud_amount <= '0;
      tab_count = 0;
      band_width = fnsr_pkg::BandReset;
      mismatches = 0;
      beats_checked = 0;
      ok_queries = 0;
      cycle_count = 0;
      hold_request = 0;
      steady_ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_band($urandom_range(0, 8388607));
      write_band(fnsr_pkg::BandReset);
      test_extremes();
      test_equal_distances();
      steady_ready = 1'b1;
      test_band_settings();
      steady_ready = 1'b0;
      test_full_table();
      test_backpressure();
      test_random(1100);
      drain_results();
      repeat (200) @(posedge clock);
      if (pending_rates.size() != 0) begin
         mismatches++;
         $display("%0d expected beats never arrived", pending_rates.size());
      end
      $display("covered %0d response beats, %0d nonzero interpolations, full table,",
               beats_checked, ok_queries);
      $display("band extremes, equal distances, long hold-offs; %0d mismatches",
               mismatches);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
